@@ src/nlfp_pkg.sv @@
`default_nettype none
package nlfp_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_UINT  = 2'd1,
    KIND_FIXED = 2'd2
  } kind_t;

  // error codes, first one seen wins
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_OVERFLOW = 3'd1,
    ERR_LETTER   = 3'd2,
    ERR_SUFFIX   = 3'd3,
    ERR_DOT      = 3'd4,
    ERR_U_FIXED  = 3'd5,
    ERR_OTHER    = 3'd6
  } err_t;

  // controller to datapath
  typedef struct packed {
    logic take;         // fold the input character into the accumulators
    logic clear;        // back to the empty-literal state
    logic div_start;    // load the divider for the fraction rounding
    logic div_step;     // one quotient bit
    logic load_direct;  // result register from the character logic
    logic load_div;     // result register from accumulator plus quotient
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;     // final character leaves a clean fixed literal
    logic div_done;     // last quotient bit is being formed
  } sts_t;

endpackage
`default_nettype wire

@@ src/nlfp_ctrl.sv @@
`default_nettype none
module nlfp_ctrl
  import nlfp_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic lit_valid,
  input  wire  logic lit_last,
  input  wire  logic res_ready,
  input  wire  sts_t sts,
  output logic       lit_ready,
  output logic       res_valid,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'b001,
    ST_DIV    = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  state_t state, state_next;
  logic   res_valid_next;
  logic   slot_free;
  logic   lit_fire;

  assign slot_free = !res_valid || res_ready;
  // a last character may need the result register right away
  assign lit_ready = (state == ST_ACCEPT) && (!lit_last || slot_free);
  assign lit_fire  = lit_valid && lit_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_ACCEPT: begin
        if (lit_fire) begin
          cmd.take = 1'b1;
          if (lit_last) begin
            if (sts.need_div) begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end else begin
              cmd.load_direct = 1'b1;
              cmd.clear       = 1'b1;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_div = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_ACCEPT;
        end
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

  assign res_valid_next = (res_valid && !res_ready) || cmd.load_direct || cmd.load_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule
`default_nettype wire

@@ src/nlfp_datapath.sv @@
`default_nettype none
module nlfp_datapath
  import nlfp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 6
) (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic [7:0]             character,
  input  wire  logic                   last,
  input  wire  cmd_t                   cmd,
  output sts_t                         sts,
  output logic [VALUE_WIDTH-1:0]       res_value,
  output kind_t                        res_kind,
  output err_t                         res_err
);

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [VALUE_WIDTH-1:0] MAX_VAL = '1;
  localparam logic [VALUE_WIDTH-1:0] LIM_10   = VALUE_WIDTH'(64'(MAX_VAL) / 64'd10);
  localparam logic [VALUE_WIDTH-1:0] LIM_16   = MAX_VAL >> 4;
  localparam logic [VALUE_WIDTH-1:0] LIM_2    = MAX_VAL >> 1;
  localparam logic [VALUE_WIDTH-1:0] LIM_FRAC =
    VALUE_WIDTH'(64'(MAX_VAL) / (64'd10 << FRAC_BITS));

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;

  // literal state
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic [VALUE_WIDTH-1:0] frac, frac_next;
  logic [VALUE_WIDTH-1:0] scale, scale_next;
  kind_t                  kind_r, kind_next;
  logic                   hex, hex_next;
  logic [7:0]             pos, pos_next;
  err_t                   err_r, err_next;

  // divider
  logic [VALUE_WIDTH:0]   rem, rem_next, rem_sh;
  logic [VALUE_WIDTH-1:0] quo, quo_next;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH:0]   divisor_ext;
  logic [VALUE_WIDTH-1:0] dividend;

  logic                   is_dig, is_uc, is_lc;
  logic [3:0]             dig;
  logic [VALUE_WIDTH-1:0] acc10, acc16, frac10, scale10;
  logic                   int_ovf;

  always_comb begin
    is_dig = (character >= CH_ZERO) && (character <= CH_NINE);
    is_uc  = (character >= CH_UA) && (character <= CH_UF);
    is_lc  = (character >= CH_LA) && (character <= CH_LF);
    if (is_dig) begin
      dig = 4'(character - CH_ZERO);
    end else if (is_uc) begin
      dig = 4'(character - CH_UA + 8'd10);
    end else begin
      dig = 4'(character - CH_LA + 8'd10);
    end
    acc10   = (acc << 3) + (acc << 1) + VALUE_WIDTH'(dig);
    acc16   = (acc << 4) + VALUE_WIDTH'(dig);
    frac10  = (frac << 3) + (frac << 1) + VALUE_WIDTH'(dig);
    scale10 = (scale << 3) + (scale << 1);
  end

  always_comb begin
    acc_next   = acc;
    frac_next  = frac;
    scale_next = scale;
    kind_next  = kind_r;
    hex_next   = hex;
    err_next   = err_r;
    pos_next   = (pos == 8'hff) ? pos : pos + 8'd1;
    if (err_r == ERR_NONE) begin
      if (is_dig) begin
        if (hex) begin
          if (acc > LIM_16) err_next = ERR_OVERFLOW;
          else acc_next = acc16;
        end else if (kind_r == KIND_FIXED) begin
          if ((frac > LIM_FRAC) || (scale > LIM_10)) begin
            err_next = ERR_OVERFLOW;
          end else begin
            frac_next  = frac10;
            scale_next = scale10;
          end
        end else begin
          if (acc > LIM_10) err_next = ERR_OVERFLOW;
          else acc_next = acc10;
        end
      end else if (is_uc || is_lc) begin
        if (!hex) err_next = ERR_LETTER;
        else if (acc > LIM_16) err_next = ERR_OVERFLOW;
        else acc_next = acc16;
      end else if ((character == CH_UP) || (character == CH_LP) ||
                   (character == CH_DOT)) begin
        if ((character != CH_DOT) && !last) begin
          err_next = ERR_SUFFIX;
        end else if ((character == CH_DOT) || (kind_r != KIND_FIXED)) begin
          // dot, or a trailing p on a non-fixed literal: integer part moves up into the fixed-point grid
          if ((kind_r == KIND_INT) && !hex) begin
            kind_next = KIND_FIXED;
            acc_next  = acc << FRAC_BITS;
          end else begin
            err_next = ERR_DOT;
          end
        end
      end else if ((character == CH_UU) || (character == CH_LU)) begin
        if (!last) err_next = ERR_SUFFIX;
        else if (kind_r == KIND_INT) kind_next = KIND_UINT;
        else err_next = ERR_U_FIXED;
      end else if ((character == CH_LX) && (kind_r == KIND_INT) && (acc == '0) &&
                   (pos == 8'd1) && !hex) begin
        hex_next = 1'b1;
      end else begin
        err_next = ERR_OTHER;
      end
    end
  end

  assign int_ovf      = (kind_next == KIND_INT) && (acc_next > LIM_2);
  assign sts.need_div = (err_next == ERR_NONE) && (kind_next == KIND_FIXED);
  assign sts.div_done = (count == CW'(VALUE_WIDTH - 1));

  // rounding half up: (frac << FRAC_BITS) + scale / 2, then divide by scale
  assign dividend    = (frac_next << FRAC_BITS) + (scale_next >> 1);
  assign divisor_ext = {1'b0, scale};
  assign rem_sh      = {rem[VALUE_WIDTH-1:0], quo[VALUE_WIDTH-1]};

  always_comb begin
    if (rem_sh >= divisor_ext) begin
      rem_next = rem_sh - divisor_ext;
      quo_next = {quo[VALUE_WIDTH-2:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      quo_next = {quo[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      acc    <= '0;
      frac   <= '0;
      scale  <= VALUE_WIDTH'(1);
      kind_r <= KIND_INT;
      hex    <= 1'b0;
      pos    <= '0;
      err_r  <= ERR_NONE;
    end else if (cmd.take) begin
      acc    <= acc_next;
      frac   <= frac_next;
      scale  <= scale_next;
      kind_r <= kind_next;
      hex    <= hex_next;
      pos    <= pos_next;
      err_r  <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.div_start) begin
      count <= '0;
    end else if (cmd.div_step) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= dividend;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      res_value <= acc_next;
      res_kind  <= kind_next;
      res_err   <= ((err_next == ERR_NONE) && int_ovf) ? ERR_OVERFLOW : err_next;
    end else if (cmd.load_div) begin
      res_value <= (scale == '0) ? acc : acc + quo;
      res_kind  <= KIND_FIXED;
      res_err   <= ERR_NONE;
    end
  end

endmodule
`default_nettype wire

@@ src/numeric_literal_to_fixed_point_unit.sv @@
`default_nettype none
// Numeric literal parser: takes the characters of one literal, one item per
// cycle unless lit_ready holds them off, with last set on the final
// character, and returns one result item per literal: the value, its kind
// (signed int, unsigned int, or signed fixed point with FRAC_BITS fraction
// bits) and the first error seen. Decimal digits, a 0x prefix, a trailing
// u, a dot and a trailing p are understood; every digit is checked for
// overflow at VALUE_WIDTH bits. A literal that ends as clean fixed point
// then runs a restoring divider for the rounded fraction, one quotient bit
// per cycle, and its result is written and the next character is taken
// only once the divider is done and the result slot is free.
// Other literals write their result in the cycle of the last character.
// The result sits in an output register, so characters of the next literal
// keep flowing while it waits; only a last character waits for the slot.
module numeric_literal_to_fixed_point_unit
  import nlfp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 6
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  // character channel
  input  wire  logic        lit_valid,
  output logic              lit_ready,
  input  wire  logic [7:0]  character,
  input  wire  logic        last,
  // result channel
  output logic              res_valid,
  input  wire  logic        res_ready,
  output logic [31:0]       value,
  output logic [1:0]        kind,
  output logic [2:0]        error
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic [VALUE_WIDTH-1:0] res_value;
  kind_t                  res_kind;
  err_t                   res_err;
  logic [63:0]            value_ext;

  // sequencer: character intake, divider run, result hand-off
  nlfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .lit_valid (lit_valid),
    .lit_last  (last),
    .res_ready (res_ready),
    .sts       (sts),
    .lit_ready (lit_ready),
    .res_valid (res_valid),
    .cmd       (cmd)
  );

  // accumulators, overflow checks, rounding divider and result register
  nlfp_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .character (character),
    .last      (last),
    .cmd       (cmd),
    .sts       (sts),
    .res_value (res_value),
    .res_kind  (res_kind),
    .res_err   (res_err)
  );

  // value port carries the low 32 bits, zero filled for narrow widths
  assign value_ext = 64'(res_value);
  assign value     = value_ext[31:0];
  assign kind      = res_kind;
  assign error     = res_err;

endmodule
`default_nettype wire
